// ===== src/tsa_pkg.sv =====
package tsa_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 14;
    localparam int FIELD_W    = 16;

    // quarter-turn index: 0 .. 2^(ANGLE_BITS-2), so one extra bit
    localparam int IDX_W    = ANGLE_BITS - 1;
    localparam int TH_SHIFT = ANGLE_BITS - 2;
    localparam logic [IDX_W-1:0] QUARTER = IDX_W'(2 ** (ANGLE_BITS - 2));

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

    // series terms; divisor k = ODD << SHIFT, divided by a reciprocal plus one correction
    localparam int NTERMS = 6;
    localparam logic [32:0] TWO32 = 33'h1_0000_0000;
    localparam int          DIV_SHIFT [NTERMS] = '{2, 1, 3, 1, 2, 1};
    localparam logic [5:0]  DIV_ODD   [NTERMS] = '{6'd39, 6'd55, 6'd9, 6'd21, 6'd5, 6'd3};
    localparam logic [31:0] DIV_RECIP [NTERMS] = '{
        32'(TWO32 / 39), 32'(TWO32 / 55), 32'(TWO32 / 9),
        32'(TWO32 / 21), 32'(TWO32 / 5),  32'(TWO32 / 3)
    };

    // sine unit: angle scale, square, three stages per term, final product
    localparam int SIN_LAT = 2 + 3 * NTERMS + 1;
    localparam int SC_LAT  = SIN_LAT + 1;
    localparam int MAT_LAT = 3;
    localparam int LAT     = SC_LAT + MAT_LAT;

    localparam int OUT_LIM = 2 ** FRAC_BITS;

    typedef struct packed {
        logic [FIELD_W-1:0] r_row3_col3;
        logic [FIELD_W-1:0] r_row3_col2;
        logic [FIELD_W-1:0] r_row3_col1;
        logic [FIELD_W-1:0] r_row2_col3;
        logic [FIELD_W-1:0] r_row2_col2;
        logic [FIELD_W-1:0] r_row2_col1;
        logic [FIELD_W-1:0] r_row1_col3;
        logic [FIELD_W-1:0] r_row1_col2;
        logic [FIELD_W-1:0] r_row1_col1;
    } tsa_matrix_t;

    // Q1.30 product, sign-magnitude, round half away from zero
    function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic [30:0] ma;
        logic [30:0] mb;
        logic [61:0] p;
        logic [31:0] r;
        ma = a[31] ? 31'(-a) : a[30:0];
        mb = b[31] ? 31'(-b) : b[30:0];
        p  = 62'(ma) * 62'(mb) + (62'd1 << 29);
        r  = 32'(p >> 30);
        return (a[31] ^ b[31]) ? -$signed(r) : $signed(r);
    endfunction

    // Q1.30 to FRAC_BITS, round half away from zero, clamp to +-1.0
    function automatic logic [FIELD_W-1:0] to_out(input logic signed [32:0] v);
        logic [32:0] m;
        logic [33:0] s;
        logic [33:0] q;
        m = v[32] ? 33'(-v) : 33'(v);
        s = 34'(m) + (34'd1 << (30 - FRAC_BITS - 1));
        q = s >> (30 - FRAC_BITS);
        if (q > 34'(OUT_LIM)) begin
            q = 34'(OUT_LIM);
        end
        return v[32] ? FIELD_W'(-q) : FIELD_W'(q);
    endfunction

endpackage

// ===== src/tsa_sin.sv =====
module tsa_sin (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [tsa_pkg::IDX_W-1:0]   idx,
    output logic [30:0]                 sin_mag
);

    localparam int N = tsa_pkg::NTERMS;

    logic [tsa_pkg::IDX_W+30:0] th_prod;
    logic [30:0] th0_reg;
    logic [30:0] th_reg  [0:N];
    logic [31:0] th2_reg [0:N-1];
    logic [30:0] f_reg   [0:N];
    logic [61:0] fin_prod;
    logic [31:0] fin_val;
    logic [30:0] sin_reg;

    assign th_prod = (tsa_pkg::IDX_W + 31)'(idx) * (tsa_pkg::IDX_W + 31)'(tsa_pkg::HALF_PI_Q30);

    always_ff @(posedge aclk) begin
        if (en) begin
            th0_reg    <= 31'(th_prod >> tsa_pkg::TH_SHIFT);
            th_reg[0]  <= th0_reg;
            th2_reg[0] <= 32'((62'(th0_reg) * 62'(th0_reg)) >> 30);
            f_reg[0]   <= tsa_pkg::Q30_ONE;
        end
    end

    // one series term per three stages: product, reciprocal multiply, correction
    for (genvar i = 0; i < N; i++) begin : g_term
        logic [62:0] pa;
        logic [63:0] pb;
        logic [37:0] qk;
        logic [37:0] rem;
        logic [31:0] q;
        logic [31:0] va_reg;
        logic [31:0] vb_reg;
        logic [31:0] q0_reg;
        logic [30:0] tha_reg;
        logic [30:0] thb_reg;

        assign pa  = 63'(th2_reg[i]) * 63'(f_reg[i]);
        assign pb  = 64'(va_reg) * 64'(tsa_pkg::DIV_RECIP[i]);
        assign qk  = 38'(q0_reg) * 38'(tsa_pkg::DIV_ODD[i]);
        assign rem = 38'(vb_reg) - qk;
        assign q   = q0_reg + 32'(rem >= 38'(tsa_pkg::DIV_ODD[i]));

        always_ff @(posedge aclk) begin
            if (en) begin
                va_reg       <= 32'((pa >> 30) >> tsa_pkg::DIV_SHIFT[i]);
                tha_reg      <= th_reg[i];
                q0_reg       <= pb[63:32];
                vb_reg       <= va_reg;
                thb_reg      <= tha_reg;
                f_reg[i+1]   <= tsa_pkg::Q30_ONE - 31'(q);
                th_reg[i+1]  <= thb_reg;
            end
        end

        // the square is not needed after the last term
        if (i < N - 1) begin : g_th2
            logic [31:0] th2a_reg;
            logic [31:0] th2b_reg;

            always_ff @(posedge aclk) begin
                if (en) begin
                    th2a_reg     <= th2_reg[i];
                    th2b_reg     <= th2a_reg;
                    th2_reg[i+1] <= th2b_reg;
                end
            end
        end
    end

    assign fin_prod = 62'(th_reg[N]) * 62'(f_reg[N]);
    assign fin_val  = 32'(fin_prod >> 30);

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= (fin_val > 32'(tsa_pkg::Q30_ONE)) ? tsa_pkg::Q30_ONE : 31'(fin_val);
        end
    end

    assign sin_mag = sin_reg;

endmodule

// ===== src/tsa_sincos.sv =====
module tsa_sincos (
    input  logic                                aclk,
    input  logic                                en,
    input  logic [tsa_pkg::ANGLE_BITS-1:0]      angle,
    output logic signed [31:0]                  sin_out,
    output logic signed [31:0]                  cos_out
);

    localparam logic [1:0] QUAD_1 = 2'd0;
    localparam logic [1:0] QUAD_2 = 2'd1;
    localparam logic [1:0] QUAD_3 = 2'd2;
    localparam logic [1:0] QUAD_4 = 2'd3;

    logic [tsa_pkg::IDX_W-1:0] idx_s;
    logic [tsa_pkg::IDX_W-1:0] idx_c;
    logic [30:0] mag_a;
    logic [30:0] mag_b;
    logic signed [31:0] sa;
    logic signed [31:0] sb;
    logic [1:0] quad_reg [0:tsa_pkg::SIN_LAT-1];
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_next;
    logic signed [31:0] cos_next;

    assign idx_s = tsa_pkg::IDX_W'(angle[tsa_pkg::ANGLE_BITS-3:0]);
    assign idx_c = tsa_pkg::QUARTER - idx_s;

    tsa_sin u_sin_a (.aclk(aclk), .en(en), .idx(idx_s), .sin_mag(mag_a));
    tsa_sin u_sin_b (.aclk(aclk), .en(en), .idx(idx_c), .sin_mag(mag_b));

    always_ff @(posedge aclk) begin
        if (en) begin
            quad_reg[0] <= angle[tsa_pkg::ANGLE_BITS-1:tsa_pkg::ANGLE_BITS-2];
            for (int i = 1; i < tsa_pkg::SIN_LAT; i++) begin
                quad_reg[i] <= quad_reg[i-1];
            end
        end
    end

    assign sa = $signed({1'b0, mag_a});
    assign sb = $signed({1'b0, mag_b});

    always_comb begin
        unique case (quad_reg[tsa_pkg::SIN_LAT-1])
            QUAD_1: begin sin_next = sa;  cos_next = sb;  end
            QUAD_2: begin sin_next = sb;  cos_next = -sa; end
            QUAD_3: begin sin_next = -sa; cos_next = -sb; end
            QUAD_4: begin sin_next = -sb; cos_next = sa;  end
            default: begin sin_next = sa; cos_next = sb;  end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

// ===== src/tsa_matrix.sv =====
module tsa_matrix (
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [31:0]          sa,
    input  logic signed [31:0]          ca,
    input  logic signed [31:0]          st,
    input  logic signed [31:0]          ct,
    input  logic signed [31:0]          ss,
    input  logic signed [31:0]          cs,
    output tsa_pkg::tsa_matrix_t        res
);

    // stage 1: all products of two sines/cosines
    logic signed [31:0] ct_ss_reg, ct_cs_reg, ca_cs_reg, sa_cs_reg, st_ss_reg;
    logic signed [31:0] ca_ss_reg, sa_ss_reg, st_cs_reg, sa_st_reg, ca_st_reg;
    logic signed [31:0] sa1_reg, ca1_reg, ct1_reg;
    // stage 2: triple products, plus the stage 1 products and ct carried along
    logic signed [31:0] sa_ctss_reg, ca_ctss_reg, sa_ctcs_reg, ca_ctcs_reg;
    logic signed [31:0] ca_cs2_reg, sa_cs2_reg, st_ss2_reg, ca_ss2_reg, sa_ss2_reg;
    logic signed [31:0] st_cs2_reg, sa_st2_reg, ca_st2_reg, ct2_reg;
    tsa_pkg::tsa_matrix_t res_reg;
    tsa_pkg::tsa_matrix_t res_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            ct_ss_reg <= tsa_pkg::mul30(ct, ss);
            ct_cs_reg <= tsa_pkg::mul30(ct, cs);
            ca_cs_reg <= tsa_pkg::mul30(ca, cs);
            sa_cs_reg <= tsa_pkg::mul30(sa, cs);
            st_ss_reg <= tsa_pkg::mul30(st, ss);
            ca_ss_reg <= tsa_pkg::mul30(ca, ss);
            sa_ss_reg <= tsa_pkg::mul30(sa, ss);
            st_cs_reg <= tsa_pkg::mul30(st, cs);
            sa_st_reg <= tsa_pkg::mul30(sa, st);
            ca_st_reg <= tsa_pkg::mul30(ca, st);
            sa1_reg   <= sa;
            ca1_reg   <= ca;
            ct1_reg   <= ct;

            sa_ctss_reg <= tsa_pkg::mul30(sa1_reg, ct_ss_reg);
            ca_ctss_reg <= tsa_pkg::mul30(ca1_reg, ct_ss_reg);
            sa_ctcs_reg <= tsa_pkg::mul30(sa1_reg, ct_cs_reg);
            ca_ctcs_reg <= tsa_pkg::mul30(ca1_reg, ct_cs_reg);
            ca_cs2_reg  <= ca_cs_reg;
            sa_cs2_reg  <= sa_cs_reg;
            st_ss2_reg  <= st_ss_reg;
            ca_ss2_reg  <= ca_ss_reg;
            sa_ss2_reg  <= sa_ss_reg;
            st_cs2_reg  <= st_cs_reg;
            sa_st2_reg  <= sa_st_reg;
            ca_st2_reg  <= ca_st_reg;
            ct2_reg     <= ct1_reg;

            res_reg <= res_next;
        end
    end

    always_comb begin
        res_next.r_row1_col1 = tsa_pkg::to_out(-33'(ca_cs2_reg) - 33'(sa_ctss_reg));
        res_next.r_row1_col2 = tsa_pkg::to_out(33'(sa_cs2_reg) - 33'(ca_ctss_reg));
        res_next.r_row1_col3 = tsa_pkg::to_out(-33'(st_ss2_reg));
        res_next.r_row2_col1 = tsa_pkg::to_out(33'(ca_ss2_reg) - 33'(sa_ctcs_reg));
        res_next.r_row2_col2 = tsa_pkg::to_out(-33'(sa_ss2_reg) - 33'(ca_ctcs_reg));
        res_next.r_row2_col3 = tsa_pkg::to_out(-33'(st_cs2_reg));
        res_next.r_row3_col1 = tsa_pkg::to_out(-33'(sa_st2_reg));
        res_next.r_row3_col2 = tsa_pkg::to_out(-33'(ca_st2_reg));
        res_next.r_row3_col3 = tsa_pkg::to_out(33'(ct2_reg));
    end

    assign res = res_reg;

endmodule

// ===== src/tilt_swing_azimuth_rotation_matrix.sv =====
// Channel   Dir  Width  Contents
// s_        in   48     azimuth_angle, tilt_angle, swing_angle
// m_        out  144    r_row1_col1 .. r_row3_col3, row by row
//
// One request per cycle while results are taken. Input to output register runs
// through the sine series units (angle scale, square, six terms of three stages
// each, final product), one quadrant fold stage and three matrix product stages.
// Reset clears only the valid bits; data registers are not reset.
// A result not taken freezes the whole pipeline, which holds every item.
module tilt_swing_azimuth_rotation_matrix (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [3*tsa_pkg::FIELD_W-1:0]       s_tdata,  // azimuth, tilt, swing
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [9*tsa_pkg::FIELD_W-1:0]       m_tdata   // r11,r12,r13,r21,..,r33
);

    localparam int FW = tsa_pkg::FIELD_W;
    localparam int AB = tsa_pkg::ANGLE_BITS;

    logic en;
    logic vld_reg [0:tsa_pkg::LAT-1];
    logic signed [31:0] sa, ca, st, ct, ss, cs;
    tsa_pkg::tsa_matrix_t res;

    assign en       = !vld_reg[tsa_pkg::LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[tsa_pkg::LAT-1];
    assign m_tdata  = res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < tsa_pkg::LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < tsa_pkg::LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    tsa_sincos u_az (.aclk(aclk), .en(en), .angle(AB'(s_tdata[FW-1:0])),
                     .sin_out(sa), .cos_out(ca));
    tsa_sincos u_tl (.aclk(aclk), .en(en), .angle(AB'(s_tdata[2*FW-1:FW])),
                     .sin_out(st), .cos_out(ct));
    tsa_sincos u_sw (.aclk(aclk), .en(en), .angle(AB'(s_tdata[3*FW-1:2*FW])),
                     .sin_out(ss), .cos_out(cs));

    tsa_matrix u_mat (.aclk(aclk), .en(en), .sa(sa), .ca(ca), .st(st), .ct(ct),
                      .ss(ss), .cs(cs), .res(res));

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg[0]) && $stable(vld_reg[tsa_pkg::LAT/2]))
        else $error("pipeline moved while stalled");

    a_diag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'($signed(res.r_row3_col3)) <= tsa_pkg::OUT_LIM
                   && int'($signed(res.r_row3_col3)) >= -tsa_pkg::OUT_LIM
                   && int'($signed(res.r_row1_col1)) <= tsa_pkg::OUT_LIM
                   && int'($signed(res.r_row1_col1)) >= -tsa_pkg::OUT_LIM))
        else $error("matrix element out of range");

endmodule

// ===== verif/tilt_swing_azimuth_rotation_matrix_checker.sv =====
module tilt_swing_azimuth_rotation_matrix_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [47:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [143:0] m_tdata,
    output int           fail_count,
    output int           pending_count,
    output int           matrix_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ABITS = tsa_pkg::ANGLE_BITS;
    localparam int FBITS = tsa_pkg::FRAC_BITS;
    localparam longint ONE30 = longint'(1) << 30;

    logic [143:0] expected_matrices [$];
    int mismatches;

    function automatic longint quarter_sine(input longint u);
        longint th;
        longint th2;
        longint f;
        int divs [6];
        divs = '{156, 110, 72, 42, 20, 6};
        th  = (u * 64'd1686629713) >>> 30;
        th2 = (th * th) >>> 30;
        f   = ONE30;
        for (int i = 0; i < 6; i++) begin
            f = ONE30 - (((th2 * f) >>> 30) / divs[i]);
        end
        f = (th * f) >>> 30;
        if (f > ONE30) begin
            f = ONE30;
        end
        return f;
    endfunction

    function automatic void angle_sin_cos(input logic [15:0] ang, output longint sn,
                                          output longint cs);
        logic [31:0] p;
        longint a;
        longint b;
        p = 32'(ang[ABITS-1:0]) << (32 - ABITS);
        a = quarter_sine(longint'(p[29:0]));
        b = quarter_sine(ONE30 - longint'(p[29:0]));
        case (p[31:30])
            2'd0: begin sn = a;  cs = b;  end
            2'd1: begin sn = b;  cs = -a; end
            2'd2: begin sn = -a; cs = -b; end
            default: begin sn = -b; cs = a; end
        endcase
    endfunction

    function automatic longint q30_product(input longint a, input longint b);
        longint r;
        r = (((a < 0) ? -a : a) * ((b < 0) ? -b : b) + (longint'(1) << 29)) >>> 30;
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic logic [15:0] to_element(input longint v);
        longint m;
        m = (((v < 0) ? -v : v) + (longint'(1) << (29 - FBITS))) >>> (30 - FBITS);
        if (m > (longint'(1) << FBITS)) begin
            m = longint'(1) << FBITS;
        end
        return (v < 0) ? 16'(-m) : 16'(m);
    endfunction

    function automatic logic [143:0] rotation_matrix(input logic [47:0] angles);
        longint sa, ca, st, ct, ss, cs, ct_ss, ct_cs;
        logic [15:0] e [9];
        angle_sin_cos(angles[15:0], sa, ca);
        angle_sin_cos(angles[31:16], st, ct);
        angle_sin_cos(angles[47:32], ss, cs);
        ct_ss = q30_product(ct, ss);
        ct_cs = q30_product(ct, cs);
        e[0] = to_element(-q30_product(ca, cs) - q30_product(sa, ct_ss));
        e[1] = to_element(q30_product(sa, cs) - q30_product(ca, ct_ss));
        e[2] = to_element(-q30_product(st, ss));
        e[3] = to_element(q30_product(ca, ss) - q30_product(sa, ct_cs));
        e[4] = to_element(-q30_product(sa, ss) - q30_product(ca, ct_cs));
        e[5] = to_element(-q30_product(st, cs));
        e[6] = to_element(-q30_product(sa, st));
        e[7] = to_element(-q30_product(ca, st));
        e[8] = to_element(ct);
        return {e[8], e[7], e[6], e[5], e[4], e[3], e[2], e[1], e[0]};
    endfunction

    assign pending_count = expected_matrices.size();

    always @(posedge aclk) begin
        logic [143:0] want;
        if (!aresetn) begin
            fail_count   <= 0;
            matrix_count <= 0;
            mismatches    = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_matrices.push_back(rotation_matrix(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                matrix_count <= matrix_count + 1;
                if (expected_matrices.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected matrix %h", m_tdata);
                    end
                end else begin
                    want = expected_matrices.pop_front();
                    for (int i = 0; i < 9; i++) begin
                        if (want[16*i +: 16] !== m_tdata[16*i +: 16]) begin
                            mismatches++;
                            if (mismatches <= 10) begin
                                $display("element r%0d%0d: expected %0d got %0d",
                                         i / 3 + 1, i % 3 + 1,
                                         $signed(want[16*i +: 16]),
                                         $signed(m_tdata[16*i +: 16]));
                            end
                        end
                    end
                end
            end
            fail_count <= mismatches;
        end
    end
endmodule

// ===== verif/tilt_swing_azimuth_rotation_matrix_test.sv =====
module tilt_swing_azimuth_rotation_matrix_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [47:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [143:0] m_tdata;
    int fail_count, pending_count, matrix_count;
    int send_idle = 0, recv_idle = 0;
    int quiet_cycles = 0;
    int sent = 0;

    localparam int QUIET_LIMIT = 20000;

    tilt_swing_azimuth_rotation_matrix dut (.*);

    tilt_swing_azimuth_rotation_matrix_checker checker_i (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            m_tready <= ($urandom_range(99) >= recv_idle);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles > QUIET_LIMIT) begin
                $display("watchdog: no progress");
                $display("tilt_swing_azimuth_rotation_matrix_test: FAIL");
                $finish;
            end
        end
    end

    // one request per call; holds tvalid until accepted
    task automatic send_angles(input logic [15:0] az, input logic [15:0] tl,
                               input logic [15:0] sw);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {sw, tl, az};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        sent++;
    endtask

    function automatic logic [15:0] pick_angle();
        logic [15:0] q;
        q = 16'($urandom_range(3)) << 14;
        case ($urandom_range(5))
            0: return q;
            1: return q + 16'($urandom_range(2)) - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] edges [8];
        edges = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF, 16'hFFFF,
                  16'h2000, 16'h0001};
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        for (int i = 0; i < 8; i++) begin
            send_angles(edges[i], edges[(i + 3) % 8], edges[(i + 5) % 8]);
        end
        for (int i = 0; i < 8; i++) begin
            send_angles(edges[(i + 1) % 8], edges[i], edges[i]);
        end
        s_tvalid <= 0;
        // drain before the random phases
        while (pending_count != 0) @(posedge aclk);
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 24 : (phase == 1) ? 87 : 0;
            recv_idle = (phase == 0) ? 87 : (phase == 1) ? 24 : 0;
            for (int n = 0; n < 165; n++) begin
                send_angles(pick_angle(), pick_angle(), pick_angle());
            end
        end
        s_tvalid <= 0;
        while (pending_count != 0) @(posedge aclk);
        repeat (tsa_pkg::LAT + 10) @(posedge aclk);
        $display("sent %0d angle triples, checked %0d matrices", sent, matrix_count);
        $display("quadrant edges, wrap points and three idling mixes covered");
        if (fail_count == 0) begin
            $display("tilt_swing_azimuth_rotation_matrix_test: PASS");
        end else begin
            $display("tilt_swing_azimuth_rotation_matrix_test: FAIL");
        end
        $finish;
    end
endmodule
